@@ sv/bog_pkg.sv @@
// Package for the broadcast offset generator: field widths, register map and
// the control struct that runs from the top level to each axis cell.
// No dependencies.
package bog_pkg;

	// Default structural sizes.
	localparam int MAX_AXES_DEF    = 4;
	localparam int EXTENT_BITS_DEF = 12;
	localparam int STRIDE_BITS_DEF = 16;

	// Fixed widths of the register and result fields.
	localparam int RANK_REG_W = 3;
	localparam int EXT_REG_W  = 48;
	localparam int STR_REG_W  = 64;
	localparam int OFF_W      = 30;
	localparam int DEST_W     = 48;

	// Configuration port: 64-bit registers at byte address 8*i.
	localparam int DATA_W    = 64;
	localparam int ADDR_W    = 6;
	localparam int REG_IDX_W = 3;
	localparam int REG_LSB   = 3;

	// Reset values: every extent and every stride is one.
	localparam logic [RANK_REG_W-1:0] RANK_RST = 3'd1;
	localparam logic [EXT_REG_W-1:0]  EXT_RST  = 48'h001001001001;
	localparam logic [STR_REG_W-1:0]  STR_RST  = 64'h0001000100010001;

	// Register indexes.
	typedef enum logic [REG_IDX_W-1:0] {
		REG_TARGET_RANK    = 3'd0,
		REG_SOURCE_RANK    = 3'd1,
		REG_TARGET_EXTENTS = 3'd2,
		REG_SOURCE_EXTENTS = 3'd3,
		REG_SOURCE_STRIDES = 3'd4
	} reg_idx_t;

	// Per-cell control for one cycle.
	typedef struct packed {
		logic step;       // a transaction is accepted this cycle
		logic clear;      // the accepted transaction restarts the walk
		logic active;     // this axis lies within the target rank
		logic active_up;  // the next faster axis lies within the target rank
		logic mapped;     // a source axis is aligned to this target axis
		logic en_s1;      // first pipeline stage loads
		logic en_s2;      // second pipeline stage loads
	} cell_ctl_t;

endpackage

@@ sv/broadcast_offset_generator_core.sv @@
// Top level of the broadcast offset generator: configuration registers, the
// row of axis cells, the element count and the pipeline handshake.
// Depends on bog_pkg, bog_cell and bog_out.
//
//   Channel   Direction  Handshake              Payload
//   in        input      in_valid / in_stall    restart
//   out       output     out_valid / out_stall  source_offset, dest_index, last, shape_error
//   config    input      psel/penable/pwrite    paddr, pwdata, prdata (pready tied high)
//
// One transaction is accepted per cycle when in_stall is low; its result is registered.
// The odometer carry ripples through the axis cells within the accepting cycle,
// which sets the one-per-cycle rate; multiply and sum take the following stages.
// Reset loads the default shape (rank one, all extents and strides one) and
// clears the odometer and element count; there is no clearing pass.
// A stalled output holds its result while bubbles ahead of it still fill.
module broadcast_offset_generator_core #(
	parameter int MAX_AXES    = bog_pkg::MAX_AXES_DEF,
	parameter int EXTENT_BITS = bog_pkg::EXTENT_BITS_DEF,
	parameter int STRIDE_BITS = bog_pkg::STRIDE_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          restart,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [bog_pkg::OFF_W-1:0]     source_offset,
	output logic [bog_pkg::DEST_W-1:0]    dest_index,
	output logic                          last,
	output logic                          shape_error,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [bog_pkg::ADDR_W-1:0]    paddr,
	input  logic [bog_pkg::DATA_W-1:0]    pwdata,
	output logic [bog_pkg::DATA_W-1:0]    prdata,
	output logic                          pready
);

	localparam int RANK_W = $clog2(MAX_AXES + 1);
	localparam int AX_W   = (MAX_AXES > 1) ? $clog2(MAX_AXES) : 1;
	localparam int PROD_W = EXTENT_BITS + STRIDE_BITS;
	localparam int EXT_WIDE_W = MAX_AXES * EXTENT_BITS + bog_pkg::EXT_REG_W;
	localparam int STR_WIDE_W = MAX_AXES * STRIDE_BITS + bog_pkg::STR_REG_W;

	logic [bog_pkg::RANK_REG_W-1:0] tr_q;
	logic [bog_pkg::RANK_REG_W-1:0] sr_q;
	logic [bog_pkg::EXT_REG_W-1:0]  te_q;
	logic [bog_pkg::EXT_REG_W-1:0]  se_q;
	logic [bog_pkg::STR_REG_W-1:0]  ss_q;

	logic                      cfg_wr;
	bog_pkg::reg_idx_t         cfg_idx;

	logic [RANK_W-1:0]         tr_c;
	logic [RANK_W-1:0]         sr_c;
	logic [RANK_W-1:0]         base;
	logic                      rank_err;

	logic [EXT_WIDE_W-1:0]     te_wide;
	logic [EXT_WIDE_W-1:0]     se_wide;
	logic [STR_WIDE_W-1:0]     ss_wide;
	logic [EXTENT_BITS-1:0]    te_arr [MAX_AXES];
	logic [EXTENT_BITS-1:0]    se_arr [MAX_AXES];
	logic [STRIDE_BITS-1:0]    st_arr [MAX_AXES];

	logic                      act   [MAX_AXES+1];
	logic                      carry [MAX_AXES+1];
	logic                      cell_err [MAX_AXES];
	logic [PROD_W-1:0]         prod_s2 [MAX_AXES];

	logic                      en1;
	logic                      en2;
	logic                      en_o;
	logic                      accept;
	logic                      v1_q;
	logic                      v2_q;
	logic                      vo_q;

	logic [bog_pkg::DEST_W-1:0] count_q;
	logic [bog_pkg::DEST_W-1:0] count_cur;
	logic                       walk_last;
	logic                       err_any;
	logic                       err_s1;
	logic                       err_s2;
	logic [bog_pkg::DEST_W-1:0] dest_s1;
	logic [bog_pkg::DEST_W-1:0] dest_s2;
	logic                       last_s1;
	logic                       last_s2;

	// Configuration port.
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign cfg_idx = bog_pkg::reg_idx_t'(
		paddr[bog_pkg::REG_LSB +: bog_pkg::REG_IDX_W]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tr_q <= bog_pkg::RANK_RST;
			sr_q <= bog_pkg::RANK_RST;
			te_q <= bog_pkg::EXT_RST;
			se_q <= bog_pkg::EXT_RST;
			ss_q <= bog_pkg::STR_RST;
		end else if (cfg_wr) begin
			case (cfg_idx)
				bog_pkg::REG_TARGET_RANK: begin
					tr_q <= pwdata[bog_pkg::RANK_REG_W-1:0];
				end
				bog_pkg::REG_SOURCE_RANK: begin
					sr_q <= pwdata[bog_pkg::RANK_REG_W-1:0];
				end
				bog_pkg::REG_TARGET_EXTENTS: begin
					te_q <= pwdata[bog_pkg::EXT_REG_W-1:0];
				end
				bog_pkg::REG_SOURCE_EXTENTS: begin
					se_q <= pwdata[bog_pkg::EXT_REG_W-1:0];
				end
				bog_pkg::REG_SOURCE_STRIDES: begin
					ss_q <= pwdata[bog_pkg::STR_REG_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// Register read-back.
	always_comb begin
		case (cfg_idx)
			bog_pkg::REG_TARGET_RANK: begin
				prdata = bog_pkg::DATA_W'(tr_q);
			end
			bog_pkg::REG_SOURCE_RANK: begin
				prdata = bog_pkg::DATA_W'(sr_q);
			end
			bog_pkg::REG_TARGET_EXTENTS: begin
				prdata = bog_pkg::DATA_W'(te_q);
			end
			bog_pkg::REG_SOURCE_EXTENTS: begin
				prdata = bog_pkg::DATA_W'(se_q);
			end
			bog_pkg::REG_SOURCE_STRIDES: begin
				prdata = bog_pkg::DATA_W'(ss_q);
			end
			default: begin
				prdata = '0;
			end
		endcase
	end

	// Ranks clamped to one through the axis count; source axes align at the end.
	always_comb begin
		if (tr_q == '0) begin
			tr_c = RANK_W'(1);
		end else if ({1'b0, tr_q} > 4'(MAX_AXES)) begin
			tr_c = RANK_W'(MAX_AXES);
		end else begin
			tr_c = RANK_W'(tr_q);
		end
		if (sr_q == '0) begin
			sr_c = RANK_W'(1);
		end else if ({1'b0, sr_q} > 4'(MAX_AXES)) begin
			sr_c = RANK_W'(MAX_AXES);
		end else begin
			sr_c = RANK_W'(sr_q);
		end
		rank_err = sr_c > tr_c;
		base     = tr_c - sr_c;
	end

	// Packed fields split per axis; fields beyond a register read as zero.
	assign te_wide = {{(MAX_AXES * EXTENT_BITS){1'b0}}, te_q};
	assign se_wide = {{(MAX_AXES * EXTENT_BITS){1'b0}}, se_q};
	assign ss_wide = {{(MAX_AXES * STRIDE_BITS){1'b0}}, ss_q};

	for (genvar a = 0; a < MAX_AXES; a++) begin : g_fields
		assign te_arr[a] = te_wide[a*EXTENT_BITS +: EXTENT_BITS];
		assign se_arr[a] = se_wide[a*EXTENT_BITS +: EXTENT_BITS];
		assign st_arr[a] = ss_wide[a*STRIDE_BITS +: STRIDE_BITS];
	end

	// Pipeline handshake: each stage loads when empty or moving on.
	assign en_o     = !vo_q || !out_stall;
	assign en2      = !v2_q || en_o;
	assign en1      = !v1_q || en2;
	assign in_stall = !en1;
	assign accept   = in_valid && en1;
	assign out_valid = vo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
			v2_q <= 1'b0;
			vo_q <= 1'b0;
		end else begin
			if (en1) begin
				v1_q <= accept;
			end
			if (en2) begin
				v2_q <= v1_q;
			end
			if (en_o) begin
				vo_q <= v2_q;
			end
		end
	end

	// Row of axis cells; the carry runs from the fastest axis downwards.
	assign act[MAX_AXES]   = 1'b0;
	assign carry[MAX_AXES] = 1'b0;

	for (genvar a = 0; a < MAX_AXES; a++) begin : g_cell
		bog_pkg::cell_ctl_t ctl;
		logic [RANK_W-1:0]  j_full;

		assign j_full = RANK_W'(a) - base;
		assign act[a] = RANK_W'(a) < tr_c;

		always_comb begin
			ctl.step      = accept;
			ctl.clear     = accept && restart;
			ctl.active    = act[a];
			ctl.active_up = act[a+1];
			ctl.mapped    = act[a] && !rank_err && (RANK_W'(a) >= base);
			ctl.en_s1     = en1;
			ctl.en_s2     = en2;
		end

		bog_cell #(
			.EXTENT_BITS(EXTENT_BITS),
			.STRIDE_BITS(STRIDE_BITS)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (ctl),
			.carry_up (carry[a+1]),
			.te       (te_arr[a]),
			.se       (se_arr[j_full[AX_W-1:0]]),
			.st       (st_arr[j_full[AX_W-1:0]]),
			.carry_out(carry[a]),
			.err      (cell_err[a]),
			.prod_s2  (prod_s2[a])
		);
	end

	// The walk ends when the slowest axis wraps.
	assign walk_last = carry[0];

	always_comb begin
		err_any = rank_err;
		for (int a = 0; a < MAX_AXES; a++) begin
			err_any = err_any | cell_err[a];
		end
	end

	// Element count, cleared by a restart and after the final element.
	assign count_cur = restart ? '0 : count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (accept) begin
			count_q <= walk_last ? '0 : count_cur + bog_pkg::DEST_W'(1);
		end
	end

	// Side data carried alongside the products.
	always_ff @(posedge clk) begin
		if (en1) begin
			err_s1  <= err_any;
			dest_s1 <= count_cur;
			last_s1 <= walk_last;
		end
		if (en2) begin
			err_s2  <= err_s1;
			dest_s2 <= dest_s1;
			last_s2 <= last_s1;
		end
	end

	bog_out #(
		.MAX_AXES   (MAX_AXES),
		.EXTENT_BITS(EXTENT_BITS),
		.STRIDE_BITS(STRIDE_BITS)
	) u_out (
		.clk          (clk),
		.en           (en_o),
		.prod_s2      (prod_s2),
		.err_s2       (err_s2),
		.dest_s2      (dest_s2),
		.last_s2      (last_s2),
		.source_offset(source_offset),
		.dest_index   (dest_index),
		.last         (last),
		.shape_error  (shape_error)
	);

endmodule

@@ sv/bog_cell.sv @@
// One axis cell of the broadcast offset generator: odometer digit, carry to
// the next slower axis, source index and its product with the stride.
// Depends on bog_pkg.
module bog_cell #(
	parameter int EXTENT_BITS = bog_pkg::EXTENT_BITS_DEF,
	parameter int STRIDE_BITS = bog_pkg::STRIDE_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  bog_pkg::cell_ctl_t             ctl,
	input  logic                           carry_up,
	input  logic [EXTENT_BITS-1:0]         te,
	input  logic [EXTENT_BITS-1:0]         se,
	input  logic [STRIDE_BITS-1:0]         st,
	output logic                           carry_out,
	output logic                           err,
	output logic [EXTENT_BITS+STRIDE_BITS-1:0] prod_s2
);

	localparam int PROD_W = EXTENT_BITS + STRIDE_BITS;

	logic [EXTENT_BITS-1:0] cnt_q;
	logic [EXTENT_BITS-1:0] cur;
	logic [EXTENT_BITS:0]   inc;
	logic                   fits;
	logic                   inc_en;
	logic [EXTENT_BITS-1:0] idx_s1;
	logic [STRIDE_BITS-1:0] st_s1;

	// The digit counts when the faster axis wrapped, or when it is the fastest.
	always_comb begin
		cur       = ctl.clear ? '0 : cnt_q;
		inc       = {1'b0, cur} + {{EXTENT_BITS{1'b0}}, 1'b1};
		fits      = inc < {1'b0, te};
		inc_en    = ctl.active && (!ctl.active_up || carry_up);
		carry_out = inc_en && !fits;
	end

	// An empty target axis, or a source extent that cannot broadcast.
	always_comb begin
		err = (ctl.active && (te == '0)) ||
			(ctl.mapped && ((se == '0) ||
			((se != te) && (se != EXTENT_BITS'(1)))));
	end

	// Odometer digit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (ctl.step) begin
			if (inc_en) begin
				cnt_q <= fits ? inc[EXTENT_BITS-1:0] : '0;
			end else if (ctl.clear) begin
				cnt_q <= '0;
			end
		end
	end

	// Source index before the advance, zero on a broadcast axis.
	always_ff @(posedge clk) begin
		if (ctl.en_s1) begin
			idx_s1 <= (ctl.mapped && (se != EXTENT_BITS'(1))) ? cur : '0;
			st_s1  <= st;
		end
	end

	// Index times stride.
	always_ff @(posedge clk) begin
		if (ctl.en_s2) begin
			prod_s2 <= PROD_W'(idx_s1) * PROD_W'(st_s1);
		end
	end

endmodule

@@ sv/bog_out.sv @@
// Output stage of the broadcast offset generator: sums the per-axis products
// and holds the result transaction until it is taken.
// Depends on bog_pkg.
module bog_out #(
	parameter int MAX_AXES    = bog_pkg::MAX_AXES_DEF,
	parameter int EXTENT_BITS = bog_pkg::EXTENT_BITS_DEF,
	parameter int STRIDE_BITS = bog_pkg::STRIDE_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              en,
	input  logic [EXTENT_BITS+STRIDE_BITS-1:0] prod_s2 [MAX_AXES],
	input  logic                              err_s2,
	input  logic [bog_pkg::DEST_W-1:0]        dest_s2,
	input  logic                              last_s2,
	output logic [bog_pkg::OFF_W-1:0]         source_offset,
	output logic [bog_pkg::DEST_W-1:0]        dest_index,
	output logic                              last,
	output logic                              shape_error
);

	localparam int PROD_W = EXTENT_BITS + STRIDE_BITS;
	localparam int EXT_W  = PROD_W + bog_pkg::OFF_W;

	logic [EXT_W-1:0]           prod_ext [MAX_AXES];
	logic [bog_pkg::OFF_W-1:0]  sum;

	// Products widened so that the low offset bits can always be taken.
	for (genvar a = 0; a < MAX_AXES; a++) begin : g_ext
		assign prod_ext[a] = {{bog_pkg::OFF_W{1'b0}}, prod_s2[a]};
	end

	// Offset modulo the offset width.
	always_comb begin
		sum = '0;
		for (int a = 0; a < MAX_AXES; a++) begin
			sum = sum + prod_ext[a][bog_pkg::OFF_W-1:0];
		end
	end

	// Result register.
	always_ff @(posedge clk) begin
		if (en) begin
			source_offset <= err_s2 ? '0 : sum;
			dest_index    <= dest_s2;
			last          <= last_s2;
			shape_error   <= err_s2;
		end
	end

endmodule

@@ sv/bog_checker.sv @@
// Port-level checks for the broadcast offset generator, bound to the top level.
// Depends on bog_pkg and broadcast_offset_generator_core.
module bog_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_stall,
	input logic                       out_valid,
	input logic                       out_stall,
	input logic [bog_pkg::OFF_W-1:0]  source_offset,
	input logic [bog_pkg::DEST_W-1:0] dest_index,
	input logic                       last,
	input logic                       shape_error
);

	logic prev_last_q;

	// Remembers whether the previous delivered transaction ended the walk.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_last_q <= 1'b0;
		end else if (out_valid && !out_stall) begin
			prev_last_q <= last;
		end
	end

	// A stalled result holds.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(source_offset) &&
		$stable(dest_index) && $stable(last) && $stable(shape_error))
		else $error("stalled result changed");

	// A shape error forces the offset to zero.
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && shape_error |-> source_offset == '0)
		else $error("offset not zero on shape error");

	// After the final element the walk starts again from index zero.
	a_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && prev_last_q |-> dest_index == '0)
		else $error("walk did not wrap to zero");

	// With no result waiting, input is never held off.
	a_no_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !in_stall)
		else $error("input stalled with empty output");

endmodule

bind broadcast_offset_generator_core bog_checker u_bog_checker (.*);

@@ test/broadcast_offset_generator_core_tb.sv @@
// Testbench for broadcast_offset_generator_core: a tracker class that walks the
// target odometer and predicts every offset, plus tasks that drive the ticks.
// Depends on bog_pkg and the RTL of broadcast_offset_generator_core.

// Tracks the shape registers and odometer, and holds the offsets still due.
class offset_tracker;
	typedef struct packed {
		logic [bog_pkg::OFF_W-1:0]  offset;
		logic [bog_pkg::DEST_W-1:0] index;
		logic                       last;
		logic                       err_flag;
	} offset_result_t;

	logic [bog_pkg::RANK_REG_W-1:0]      target_rank;
	logic [bog_pkg::RANK_REG_W-1:0]      source_rank;
	logic [bog_pkg::EXT_REG_W-1:0]       target_ext;
	logic [bog_pkg::EXT_REG_W-1:0]       source_ext;
	logic [bog_pkg::STR_REG_W-1:0]       source_str;
	logic [bog_pkg::EXTENT_BITS_DEF-1:0] counter [bog_pkg::MAX_AXES_DEF];
	logic [bog_pkg::DEST_W-1:0]          element_count;
	offset_result_t                      pending_offsets [$];
	int                                  mismatches;

	function new();
		target_rank = bog_pkg::RANK_RST;
		source_rank = bog_pkg::RANK_RST;
		target_ext = bog_pkg::EXT_RST;
		source_ext = bog_pkg::EXT_RST;
		source_str = bog_pkg::STR_RST;
		foreach (counter[i])
			counter[i] = '0;
		element_count = '0;
		mismatches = 0;
	endfunction

	// Mirror of a register write on the configuration port.
	function void write_reg(bog_pkg::reg_idx_t idx, logic [bog_pkg::DATA_W-1:0] value);
		case (idx)
			bog_pkg::REG_TARGET_RANK: target_rank = value[bog_pkg::RANK_REG_W-1:0];
			bog_pkg::REG_SOURCE_RANK: source_rank = value[bog_pkg::RANK_REG_W-1:0];
			bog_pkg::REG_TARGET_EXTENTS: target_ext = value[bog_pkg::EXT_REG_W-1:0];
			bog_pkg::REG_SOURCE_EXTENTS: source_ext = value[bog_pkg::EXT_REG_W-1:0];
			bog_pkg::REG_SOURCE_STRIDES: source_str = value[bog_pkg::STR_REG_W-1:0];
			default: ;
		endcase
	endfunction

	// Ranks outside the legal range are clamped into it.
	function int unsigned clamp_rank(logic [bog_pkg::RANK_REG_W-1:0] r);
		if (r == 0)
			return 1;
		if (r > bog_pkg::MAX_AXES_DEF)
			return bog_pkg::MAX_AXES_DEF;
		return r;
	endfunction

	// Works out the offset for one accepted transaction and advances the odometer.
	function void accept_tick(logic restart_bit);
		int unsigned tr, sr, base, se, te, st, idx, nxt, i;
		logic [63:0] sum;
		logic err, carry;
		offset_result_t res;
		tr = clamp_rank(target_rank);
		sr = clamp_rank(source_rank);
		err = 1'b0;
		sum = '0;
		if (restart_bit) begin
			foreach (counter[k])
				counter[k] = '0;
			element_count = '0;
		end
		// Any zero target extent within the rank is a shape error.
		for (i = 0; i < tr; i++)
			if (target_ext[i*bog_pkg::EXTENT_BITS_DEF +: bog_pkg::EXTENT_BITS_DEF] == 0)
				err = 1'b1;
		// Source axes line up with the trailing target axes.
		if (sr > tr) begin
			err = 1'b1;
		end else begin
			base = tr - sr;
			for (i = 0; i < sr; i++) begin
				se = source_ext[i*bog_pkg::EXTENT_BITS_DEF +: bog_pkg::EXTENT_BITS_DEF];
				te = target_ext[(base+i)*bog_pkg::EXTENT_BITS_DEF +:
					bog_pkg::EXTENT_BITS_DEF];
				st = source_str[i*bog_pkg::STRIDE_BITS_DEF +: bog_pkg::STRIDE_BITS_DEF];
				idx = (se == 1) ? 0 : counter[base+i];
				if (se == 0 || (se != te && se != 1))
					err = 1'b1;
				sum += idx * st;
			end
		end
		res.index = element_count;
		// Odometer step: the last target axis counts fastest.
		carry = 1'b1;
		for (i = tr; i > 0 && carry; i--) begin
			te = target_ext[(i-1)*bog_pkg::EXTENT_BITS_DEF +: bog_pkg::EXTENT_BITS_DEF];
			nxt = counter[i-1] + 1;
			if (nxt < te) begin
				counter[i-1] = nxt[bog_pkg::EXTENT_BITS_DEF-1:0];
				carry = 1'b0;
			end else begin
				counter[i-1] = '0;
			end
		end
		element_count = carry ? '0 : element_count + 1'b1;
		res.last = carry;
		res.err_flag = err;
		res.offset = err ? '0 : sum[bog_pkg::OFF_W-1:0];
		pending_offsets = {pending_offsets, res};
	endfunction

	function void flag(string text);
		mismatches++;
		if (mismatches <= 10)
			$display("mismatch at %0t: %s", $realtime, text);
	endfunction

	// Compares one accepted result against the oldest offset due.
	function void check_offset(logic [bog_pkg::OFF_W-1:0] offset,
			logic [bog_pkg::DEST_W-1:0] index, logic last_bit, logic err_bit);
		offset_result_t want;
		if (pending_offsets.size() == 0) begin
			flag($sformatf("result with no transaction waiting, offset %0h index %0h",
				offset, index));
			return;
		end
		want = pending_offsets.pop_front();
		if (offset !== want.offset)
			flag($sformatf("source_offset expected %0h got %0h", want.offset, offset));
		if (index !== want.index)
			flag($sformatf("dest_index expected %0h got %0h", want.index, index));
		if (last_bit !== want.last)
			flag($sformatf("last expected %0b got %0b", want.last, last_bit));
		if (err_bit !== want.err_flag)
			flag($sformatf("shape_error expected %0b got %0b", want.err_flag, err_bit));
	endfunction

	function void finish_check();
		if (pending_offsets.size() != 0)
			flag($sformatf("%0d results never arrived", pending_offsets.size()));
	endfunction
endclass

module broadcast_offset_generator_core_tb;
	localparam int EB = bog_pkg::EXTENT_BITS_DEF;
	localparam int SB = bog_pkg::STRIDE_BITS_DEF;
	localparam int NA = bog_pkg::MAX_AXES_DEF;

	logic                       clk;
	logic                       arst_n;
	logic                       in_valid;
	logic                       in_stall;
	logic                       restart;
	logic                       out_valid;
	logic                       out_stall;
	logic [bog_pkg::OFF_W-1:0]  source_offset;
	logic [bog_pkg::DEST_W-1:0] dest_index;
	logic                       last;
	logic                       shape_error;
	logic                       psel;
	logic                       penable;
	logic                       pwrite;
	logic [bog_pkg::ADDR_W-1:0] paddr;
	logic [bog_pkg::DATA_W-1:0] pwdata;
	logic [bog_pkg::DATA_W-1:0] prdata;
	logic                       pready;

	offset_tracker tracker;
	bit quiet;
	bit long_hold;
	int hold_left;
	int burst_left;

	broadcast_offset_generator_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.restart(restart),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.source_offset(source_offset),
		.dest_index(dest_index),
		.last(last),
		.shape_error(shape_error),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	// Both channels are sampled at the rising edge; inputs are noted before results.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				tracker.accept_tick(restart);
			if (out_valid && !out_stall)
				tracker.check_offset(source_offset, dest_index, last, shape_error);
		end
	end

	// Receiver: random stall bursts, one long hold on request, none when quiet.
	initial begin
		out_stall = 1'b0;
		hold_left = 0;
		burst_left = 0;
		forever begin
			@(negedge clk);
			if (long_hold) begin
				long_hold = 1'b0;
				hold_left = 40;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (burst_left > 0) begin
				burst_left--;
				out_stall <= 1'b1;
			end else if (!quiet && $urandom_range(0, 4) == 0) begin
				burst_left = $urandom_range(1, 3) - 1;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// One register write: setup cycle, then access cycle until pready.
	task automatic write_reg(bog_pkg::reg_idx_t idx, logic [bog_pkg::DATA_W-1:0] value);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= bog_pkg::ADDR_W'(int'(idx) << bog_pkg::REG_LSB);
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		tracker.write_reg(idx, value);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic set_shape(logic [bog_pkg::DATA_W-1:0] tr, logic [bog_pkg::DATA_W-1:0] sr,
			logic [bog_pkg::DATA_W-1:0] t_ext, logic [bog_pkg::DATA_W-1:0] s_ext,
			logic [bog_pkg::DATA_W-1:0] str);
		write_reg(bog_pkg::REG_TARGET_RANK, tr);
		write_reg(bog_pkg::REG_SOURCE_RANK, sr);
		write_reg(bog_pkg::REG_TARGET_EXTENTS, t_ext);
		write_reg(bog_pkg::REG_SOURCE_EXTENTS, s_ext);
		write_reg(bog_pkg::REG_SOURCE_STRIDES, str);
	endtask

	// Offers one transaction, waits until it is taken, then maybe idles a little.
	task automatic send_tick(logic rs, bit allow_gap);
		@(negedge clk);
		in_valid <= 1'b1;
		restart <= rs;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		if (allow_gap && !quiet && $urandom_range(0, 3) == 0) begin
			repeat ($urandom_range(1, 3)) begin
				@(negedge clk);
				in_valid <= 1'b0;
			end
		end
	endtask

	// Stops offering and waits until every predicted offset has been checked.
	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (tracker.pending_offsets.size() != 0)
			@(posedge clk);
		repeat (4)
			@(posedge clk);
	endtask

	function automatic logic pick_restart();
		return $urandom_range(0, 15) == 0;
	endfunction

	function automatic logic [EB-1:0] pick_extent();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			2: return EB'($urandom);
			default: return EB'($urandom_range(1, 3));
		endcase
	endfunction

	function automatic logic [SB-1:0] pick_stride();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return '1;
			default: return SB'($urandom);
		endcase
	endfunction

	// Random shape: mostly shapes that broadcast cleanly, otherwise raw noise.
	task automatic random_shape(bit well_formed);
		int unsigned tr, sr, i;
		logic [bog_pkg::EXT_REG_W-1:0] t_ext, s_ext;
		logic [bog_pkg::STR_REG_W-1:0] strides;
		logic [EB-1:0] te;
		t_ext = '0;
		s_ext = '0;
		for (i = 0; i < NA; i++)
			strides[i*SB +: SB] = pick_stride();
		if (well_formed) begin
			tr = $urandom_range(1, NA);
			sr = $urandom_range(1, tr);
			for (i = 0; i < NA; i++)
				t_ext[i*EB +: EB] = ($urandom_range(0, 9) == 0) ?
					'1 : EB'($urandom_range(1, 3));
			for (i = 0; i < NA; i++) begin
				te = (i < sr) ? t_ext[(tr-sr+i)*EB +: EB] : EB'($urandom_range(1, 3));
				s_ext[i*EB +: EB] = $urandom_range(0, 1) ? te : EB'(1);
			end
			set_shape(bog_pkg::DATA_W'(tr), bog_pkg::DATA_W'(sr), bog_pkg::DATA_W'(t_ext),
				bog_pkg::DATA_W'(s_ext), strides);
		end else begin
			for (i = 0; i < NA; i++) begin
				t_ext[i*EB +: EB] = pick_extent();
				s_ext[i*EB +: EB] = pick_extent();
			end
			// Upper data bits are random too; the registers keep only their width.
			set_shape({$urandom, $urandom}, {$urandom, $urandom},
				{16'($urandom), t_ext}, {16'($urandom), s_ext}, strides);
		end
	endtask

	// Main sequence: reset, directed shapes, random phases, pressure, quiet tail.
	initial begin
		in_valid = 1'b0;
		restart = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		quiet = 1'b0;
		long_hold = 1'b0;
		tracker = new();
		arst_n = 1'b0;
		repeat (10)
			@(negedge clk);
		arst_n <= 1'b1;

		// Reset shape: every transaction is the final element.
		send_tick(1'b0, 1'b1);
		send_tick(1'b1, 1'b1);
		drain();

		// Rank-2 source broadcast along one axis of a rank-3 target, full wrap.
		set_shape(3, 2, {12'd1, 12'd2, 12'd2, 12'd2}, {12'd1, 12'd1, 12'd2, 12'd1},
			{16'd0, 16'd0, 16'hffff, 16'hffff});
		repeat (9)
			send_tick(1'b0, 1'b1);
		drain();

		// Source rank above target rank.
		set_shape(1, 4, {12'd1, 12'd1, 12'd1, 12'd2}, {12'd1, 12'd1, 12'd1, 12'd2},
			{16'd1, 16'd1, 16'd1, 16'd1});
		send_tick(1'b1, 1'b1);
		send_tick(1'b0, 1'b1);
		drain();

		// Mismatched extents, then a zero target extent and a zero source extent.
		set_shape(2, 2, {12'd1, 12'd1, 12'd2, 12'd3}, {12'd1, 12'd1, 12'd2, 12'd2},
			{16'd3, 16'd5, 16'd7, 16'd9});
		send_tick(1'b1, 1'b1);
		drain();
		write_reg(bog_pkg::REG_TARGET_EXTENTS, {12'd1, 12'd1, 12'd2, 12'd0});
		send_tick(1'b0, 1'b1);
		drain();
		write_reg(bog_pkg::REG_TARGET_EXTENTS, {12'd1, 12'd1, 12'd2, 12'd3});
		write_reg(bog_pkg::REG_SOURCE_EXTENTS, {12'd1, 12'd1, 12'd0, 12'd3});
		send_tick(1'b0, 1'b1);
		drain();

		// Ranks of zero and seven are clamped.
		set_shape(0, 7, {12'd2, 12'd2, 12'd2, 12'd2}, {12'd2, 12'd2, 12'd2, 12'd2},
			{16'd1, 16'd2, 16'd3, 16'd4});
		send_tick(1'b0, 1'b1);
		drain();
		set_shape(7, 0, {12'd2, 12'd2, 12'd2, 12'd2}, {12'd2, 12'd2, 12'd2, 12'd2},
			{16'd1, 16'd2, 16'd3, 16'd4});
		send_tick(1'b0, 1'b1);
		drain();

		// Widest extents and strides on every axis.
		set_shape(4, 4, '1, '1, '1);
		send_tick(1'b1, 1'b1);
		send_tick(1'b0, 1'b1);
		send_tick(1'b0, 1'b1);
		drain();

		// Random phases; counters left over from the last shape are kept.
		for (int phase = 0; phase < 6; phase++) begin
			random_shape($urandom_range(0, 3) != 0);
			repeat (50)
				send_tick(pick_restart(), 1'b1);
			drain();
		end

		// Long receiver hold while transactions keep coming back to back.
		random_shape(1'b1);
		@(posedge clk);
		long_hold = 1'b1;
		repeat (30)
			send_tick(pick_restart(), 1'b0);
		drain();

		// Closing stretch with no idling on either side.
		quiet = 1'b1;
		random_shape(1'b1);
		repeat (60)
			send_tick(pick_restart(), 1'b1);
		drain();

		repeat (10)
			@(posedge clk);
		tracker.finish_check();
		if (tracker.mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	// Watchdog for a hung handshake.
	initial begin
		#400000;
		$display("end of test: mismatches");
		$finish;
	end
endmodule
